@@ rtl/core/pwrc_pkg.sv @@
// ----------------------------------------------------------------------------
// pwrc_pkg
// Shared widths, register codes, payload and control types for the pick
// window energy classifier.
// ----------------------------------------------------------------------------
package pwrc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int INDEX_BITS  = 16;
  localparam int OFF_W       = 16;
  // signed width that holds pick plus any offset
  localparam int POS_W       = ((INDEX_BITS > OFF_W) ? INDEX_BITS : OFF_W) + 2;
  localparam int LEN_W       = INDEX_BITS + 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int ENERGY_W    = 64;
  localparam int HALF_W      = ENERGY_W / 2;
  // 2.2 squared taken as RATIO_NUM / RATIO_DEN
  localparam int RATIO_NUM   = 484;
  localparam int RATIO_DEN   = 100;
  localparam int NUM_W       = $clog2(RATIO_NUM + 1);
  localparam int K_W         = LEN_W + NUM_W;
  localparam int PP_W        = HALF_W + K_W;
  localparam int PROD_W      = ENERGY_W + K_W;
  localparam int NUM_WIN     = 4;
  localparam int WIN_IDX_W   = $clog2(NUM_WIN);
  localparam int MUL_STEPS   = 2 * NUM_WIN;
  localparam int STEP_W      = $clog2(MUL_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 5;

  localparam int WIN_BEFORE  = 0;
  localparam int WIN_HIT     = 1;
  localparam int WIN_HALF    = 2;
  localparam int WIN_AFTER   = 3;

  localparam logic signed [OFF_W-1:0] RST_BEFORE_START = -16'sd3000;
  localparam logic signed [OFF_W-1:0] RST_BEFORE_END   = -16'sd1000;
  localparam logic signed [OFF_W-1:0] RST_HIT_START    = -16'sd500;
  localparam logic signed [OFF_W-1:0] RST_HIT_END      = 16'sd1500;
  localparam logic signed [OFF_W-1:0] RST_HALF_END     = 16'sd700;
  localparam logic signed [OFF_W-1:0] RST_AFTER_END    = 16'sd2700;

  typedef enum logic [2:0] {
    REG_BEFORE_START,
    REG_BEFORE_END,
    REG_HIT_START,
    REG_HIT_END,
    REG_HALF_END,
    REG_AFTER_END
  } reg_idx_e;

  typedef enum logic [1:0] {
    GRADE_C = 2'd0,
    GRADE_B = 2'd1,
    GRADE_A = 2'd2
  } grade_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic signed [OFF_W-1:0] before_start;
    logic signed [OFF_W-1:0] before_end;
    logic signed [OFF_W-1:0] hit_start;
    logic signed [OFF_W-1:0] hit_end;
    logic signed [OFF_W-1:0] half_end;
    logic signed [OFF_W-1:0] after_end;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [INDEX_BITS-1:0]         pick_position;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0] quality_grade;
    logic [3:0] window_fault_mask;
  } out_item_t;

  // one finished trace: energy per window, the length factor it is
  // cross-multiplied with, and the window faults
  typedef struct packed {
    logic [NUM_WIN-1:0][ENERGY_W-1:0] energy;
    logic [NUM_WIN-1:0][K_W-1:0]      weight;
    logic [NUM_WIN-1:0]               fault;
  } trace_sum_t;

endpackage

@@ rtl/core/pwrc_regs.sv @@
// ----------------------------------------------------------------------------
// pwrc_regs
// APB-style register file holding the six window offsets.
// ----------------------------------------------------------------------------
module pwrc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pwrc_pkg::DATA_W-1:0]   pwdata,
  output logic [pwrc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pwrc_pkg::cfg_t                cfg_o
);
  import pwrc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.before_start <= RST_BEFORE_START;
      cfg_q.before_end   <= RST_BEFORE_END;
      cfg_q.hit_start    <= RST_HIT_START;
      cfg_q.hit_end      <= RST_HIT_END;
      cfg_q.half_end     <= RST_HALF_END;
      cfg_q.after_end    <= RST_AFTER_END;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BEFORE_START: cfg_q.before_start <= pwdata[OFF_W-1:0];
        REG_BEFORE_END:   cfg_q.before_end   <= pwdata[OFF_W-1:0];
        REG_HIT_START:    cfg_q.hit_start    <= pwdata[OFF_W-1:0];
        REG_HIT_END:      cfg_q.hit_end      <= pwdata[OFF_W-1:0];
        REG_HALF_END:     cfg_q.half_end     <= pwdata[OFF_W-1:0];
        REG_AFTER_END:    cfg_q.after_end    <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BEFORE_START: prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_q.before_start};
      REG_BEFORE_END:   prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_q.before_end};
      REG_HIT_START:    prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_q.hit_start};
      REG_HIT_END:      prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_q.hit_end};
      REG_HALF_END:     prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_q.half_end};
      REG_AFTER_END:    prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_q.after_end};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/pwrc_front.sv @@
// ----------------------------------------------------------------------------
// pwrc_front
// Sample front end: counts samples, tests them against the four windows,
// squares and accumulates, and on the last sample of a trace pushes the
// window sums, length factors and faults into the trace queue.
// ----------------------------------------------------------------------------
module pwrc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  pwrc_pkg::in_item_t   in_item_i,
  output logic                 in_stall_o,
  input  pwrc_pkg::cfg_t       cfg_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output pwrc_pkg::trace_sum_t entry_o
);
  import pwrc_pkg::*;

  typedef logic signed [POS_W-1:0] pos_t;

  function automatic pos_t at_offset(logic [INDEX_BITS-1:0] pick,
                                     logic signed [OFF_W-1:0] off);
    pos_t p;
    pos_t o;
    p = $signed({{(POS_W-INDEX_BITS){1'b0}}, pick});
    o = $signed({{(POS_W-OFF_W){off[OFF_W-1]}}, off});
    return p + o;
  endfunction

  logic                   advance;
  logic                   accept;
  logic [INDEX_BITS-1:0]  cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic [LEN_W-1:0]       npts;
  pos_t                   idx_pos;
  pos_t                   start_s [NUM_WIN];
  pos_t                   end_s   [NUM_WIN];
  logic [NUM_WIN-1:0]     hit_s;

  logic                   s1_vld_q;
  logic [SAMPLE_BITS-1:0] s1_mag_q;
  logic [NUM_WIN-1:0]     s1_hit_q;
  logic                   s1_last_q;
  logic [LEN_W-1:0]       s1_npts_q;
  pos_t                   s1_start_q [NUM_WIN];
  pos_t                   s1_end_q   [NUM_WIN];

  pos_t                   npts_pos;
  logic [NUM_WIN-1:0]     fault_s;
  logic [LEN_W-1:0]       len_s [NUM_WIN];
  logic [SQ_W-1:0]        sq_s;

  logic                   s2_vld_q;
  logic [SQ_W-1:0]        s2_sq_q;
  logic [NUM_WIN-1:0]     s2_hit_q;
  logic                   s2_last_q;
  logic [NUM_WIN-1:0]     s2_fault_q;
  logic [LEN_W-1:0]       s2_len_q [NUM_WIN];

  logic [ENERGY_W-1:0]    acc_q   [NUM_WIN];
  logic [ENERGY_W-1:0]    sum_s   [NUM_WIN];
  logic [ENERGY_W-1:0]    sq_ext;

  // hold the whole pipe while a finished trace waits for queue space
  assign advance    = !(s2_vld_q && s2_last_q && q_full_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  assign cnt_d = in_item_i.last_sample ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // stage 0: magnitude, window bounds and membership
  assign raw     = in_item_i.sample_value;
  assign mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign npts    = {1'b0, cnt_q} + 1'b1;
  assign idx_pos = $signed({{(POS_W-INDEX_BITS){1'b0}}, cnt_q});

  always_comb begin
    start_s[WIN_BEFORE] = at_offset(in_item_i.pick_position, cfg_i.before_start);
    end_s[WIN_BEFORE]   = at_offset(in_item_i.pick_position, cfg_i.before_end);
    start_s[WIN_HIT]    = at_offset(in_item_i.pick_position, cfg_i.hit_start);
    end_s[WIN_HIT]      = at_offset(in_item_i.pick_position, cfg_i.hit_end);
    start_s[WIN_HALF]   = start_s[WIN_HIT];
    end_s[WIN_HALF]     = at_offset(in_item_i.pick_position, cfg_i.half_end);
    start_s[WIN_AFTER]  = end_s[WIN_HALF];
    end_s[WIN_AFTER]    = at_offset(in_item_i.pick_position, cfg_i.after_end);
    for (int w = 0; w < NUM_WIN; w++) begin
      hit_s[w] = (idx_pos >= start_s[w]) && (idx_pos <= end_s[w]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_mag_q  <= mag;
      s1_hit_q  <= hit_s;
      s1_last_q <= in_item_i.last_sample;
      s1_npts_q <= npts;
      for (int w = 0; w < NUM_WIN; w++) begin
        s1_start_q[w] <= start_s[w];
        s1_end_q[w]   <= end_s[w];
      end
    end
  end

  // stage 1: square, bound checks and window lengths
  assign sq_s     = s1_mag_q * s1_mag_q;
  assign npts_pos = $signed({{(POS_W-LEN_W){1'b0}}, s1_npts_q});

  always_comb begin
    for (int w = 0; w < NUM_WIN; w++) begin
      fault_s[w] = (s1_start_q[w] < 0) || (s1_end_q[w] >= npts_pos) ||
                   (s1_end_q[w] < s1_start_q[w]);
      len_s[w]   = fault_s[w] ? '0 : LEN_W'(s1_end_q[w] - s1_start_q[w] + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_sq_q    <= sq_s;
      s2_hit_q   <= s1_hit_q;
      s2_last_q  <= s1_last_q;
      s2_fault_q <= fault_s;
      for (int w = 0; w < NUM_WIN; w++) begin
        s2_len_q[w] <= len_s[w];
      end
    end
  end

  // stage 2: accumulate, and drop the sums after the last sample
  assign sq_ext = {{(ENERGY_W-SQ_W){1'b0}}, s2_sq_q};

  always_comb begin
    for (int w = 0; w < NUM_WIN; w++) begin
      sum_s[w] = acc_q[w] + (s2_hit_q[w] ? sq_ext : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WIN; w++) begin
        acc_q[w] <= '0;
      end
    end else if (advance && s2_vld_q) begin
      for (int w = 0; w < NUM_WIN; w++) begin
        acc_q[w] <= s2_last_q ? '0 : sum_s[w];
      end
    end
  end

  assign push_o = advance && s2_vld_q && s2_last_q;

  always_comb begin
    for (int w = 0; w < NUM_WIN; w++) begin
      entry_o.energy[w] = sum_s[w];
    end
    // before is weighed by hit length and the ratio, and so on crosswise
    entry_o.weight[WIN_BEFORE] = K_W'(s2_len_q[WIN_HIT]) * K_W'(RATIO_NUM);
    entry_o.weight[WIN_HIT]    = K_W'(s2_len_q[WIN_BEFORE]) * K_W'(RATIO_DEN);
    entry_o.weight[WIN_HALF]   = K_W'(s2_len_q[WIN_AFTER]);
    entry_o.weight[WIN_AFTER]  = K_W'(s2_len_q[WIN_HALF]);
    entry_o.fault              = s2_fault_q;
  end

endmodule

@@ rtl/core/pwrc_queue.sv @@
// ----------------------------------------------------------------------------
// pwrc_queue
// Short FIFO of finished trace summaries between front and back end.
// ----------------------------------------------------------------------------
module pwrc_queue #(
  parameter int Depth = pwrc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pwrc_pkg::trace_sum_t entry_i,
  input  logic                 pop_i,
  output pwrc_pkg::trace_sum_t head_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import pwrc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  trace_sum_t      slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/core/pwrc_back.sv @@
// ----------------------------------------------------------------------------
// pwrc_back
// Grading back end: forms the four cross products with one shared
// 32-bit multiplier over eight steps, compares them and issues the grade.
// ----------------------------------------------------------------------------
module pwrc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwrc_pkg::trace_sum_t head_i,
  input  logic                 q_empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output pwrc_pkg::out_item_t  out_item_o,
  input  logic                 out_stall_i
);
  import pwrc_pkg::*;

  back_state_e          state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [WIN_IDX_W-1:0] mul_win;
  logic [HALF_W-1:0]    mul_a;
  logic [K_W-1:0]       mul_b;
  logic [PP_W-1:0]      pp_d, pp_q;
  logic [STEP_W-1:0]    pp_sel_q;
  logic                 pp_vld_q;
  logic [WIN_IDX_W-1:0] acc_win;
  logic [PROD_W-1:0]    prod_q [NUM_WIN];
  logic                 load_out;
  logic                 out_vld_q;
  out_item_t            out_item_q;
  logic                 grade_b, grade_a;
  grade_e               grade;

  // step picks window (upper bits) and energy half (low bit), low half first
  assign mul_win = step_q[STEP_W-1:1];
  assign mul_a   = step_q[0] ? head_i.energy[mul_win][ENERGY_W-1:HALF_W]
                             : head_i.energy[mul_win][HALF_W-1:0];
  assign mul_b   = head_i.weight[mul_win];
  assign pp_d    = mul_a * mul_b;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = BK_MUL;
          step_d  = '0;
        end
      end
      BK_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_d = BK_DONE;
      end
      BK_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          load_out = 1'b1;
          pop_o    = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      step_q    <= '0;
      pp_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      pp_vld_q  <= (state_q == BK_MUL);
      out_vld_q <= load_out || (out_vld_q && out_stall_i);
    end
  end

  assign acc_win = pp_sel_q[STEP_W-1:1];

  always_ff @(posedge clk_i) begin
    pp_q     <= pp_d;
    pp_sel_q <= step_q;
    if (pp_vld_q) begin
      prod_q[acc_win] <= pp_sel_q[0] ? prod_q[acc_win] + {pp_q, {HALF_W{1'b0}}}
                                     : PROD_W'(pp_q);
    end
    if (load_out) begin
      out_item_q.quality_grade     <= grade;
      out_item_q.window_fault_mask <= head_i.fault;
    end
  end

  // a faulted window counts as rms -1
  always_comb begin
    if (head_i.fault[WIN_BEFORE]) begin
      grade_b = 1'b1;
    end else if (head_i.fault[WIN_HIT]) begin
      grade_b = 1'b0;
    end else begin
      grade_b = prod_q[WIN_BEFORE] < prod_q[WIN_HIT];
    end
    grade_a = grade_b && !head_i.fault[WIN_HALF] &&
              (head_i.fault[WIN_AFTER] || (prod_q[WIN_AFTER] < prod_q[WIN_HALF]));
    grade   = grade_a ? GRADE_A : (grade_b ? GRADE_B : GRADE_C);
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/core/pick_window_rms_classifier.sv @@
// ----------------------------------------------------------------------------
// pick_window_rms_classifier
// Throughput: one sample per cycle while no finished trace waits for queue space;
// the back end grades one trace at a time on its shared multiplier.
// Reset: offsets take their defaults, sums and counter clear, queue empties.
// ----------------------------------------------------------------------------
module pick_window_rms_classifier #(
  parameter int QueueDepth = pwrc_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  pwrc_pkg::in_item_t            in_item_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output pwrc_pkg::out_item_t           out_item_o,
  input  logic                          out_stall_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pwrc_pkg::DATA_W-1:0]   pwdata,
  output logic [pwrc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import pwrc_pkg::*;

  cfg_t       cfg;
  trace_sum_t entry;
  trace_sum_t head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  pwrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  pwrc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pwrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

@@ rtl/core/pwrc_checker.sv @@
// ----------------------------------------------------------------------------
// pwrc_checker
// Port-level checks on the result channel: beat hold under stall and
// consistency of the grade with the window fault mask.
// ----------------------------------------------------------------------------
module pwrc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input pwrc_pkg::out_item_t out_item_o,
  input logic                out_stall_i
);
  import pwrc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result beat changed while stalled");

  a_before_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.window_fault_mask[WIN_BEFORE]
      |-> out_item_o.quality_grade != GRADE_C)
    else $error("faulted before window graded C");

  a_hit_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.window_fault_mask[WIN_BEFORE] &&
      out_item_o.window_fault_mask[WIN_HIT]
      |-> out_item_o.quality_grade == GRADE_C)
    else $error("faulted hit window not graded C");

  a_half_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.window_fault_mask[WIN_HALF]
      |-> out_item_o.quality_grade != GRADE_A)
    else $error("faulted half window graded A");

endmodule

bind pick_window_rms_classifier pwrc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o),
  .out_stall_i (out_stall_i)
);

@@ verif/pwrc_grade_checker.sv @@
// ----------------------------------------------------------------------------
// pwrc_grade_checker
// Watches the sample, grade and register channels of the pick window energy
// classifier. Keeps its own window sums and offsets, predicts one grade beat
// per finished trace and compares every grade beat with the oldest one due.
// ----------------------------------------------------------------------------
module pwrc_grade_checker
  import pwrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  in_item_t           in_item_i,
  input  logic               in_stall_i,
  input  logic               out_valid_i,
  input  out_item_t          out_item_i,
  input  logic               out_stall_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 mismatch_count_o,
  output int                 pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                  win_cfg;
  logic [INDEX_BITS-1:0] trace_index;
  logic [ENERGY_W-1:0]   win_energy [NUM_WIN];
  out_item_t             grade_queue [$];
  int                    mismatches = 0;

  task automatic clear_sums();
    trace_index = '0;
    for (int k = 0; k < NUM_WIN; k++) win_energy[k] = '0;
  endtask

  task automatic write_offset(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    case (reg_idx_e'(addr[PADDR_W-1:2]))
      REG_BEFORE_START: win_cfg.before_start = data[OFF_W-1:0];
      REG_BEFORE_END:   win_cfg.before_end   = data[OFF_W-1:0];
      REG_HIT_START:    win_cfg.hit_start    = data[OFF_W-1:0];
      REG_HIT_END:      win_cfg.hit_end      = data[OFF_W-1:0];
      REG_HALF_END:     win_cfg.half_end     = data[OFF_W-1:0];
      REG_AFTER_END:    win_cfg.after_end    = data[OFF_W-1:0];
      default: ;
    endcase
  endtask

  // Add one sample into the window sums; grade the trace on its last sample.
  task automatic take_sample(input in_item_t s);
    longint              lo [NUM_WIN];
    longint              hi [NUM_WIN];
    logic [ENERGY_W-1:0] span [NUM_WIN];
    longint              pick, idx, val, npts;
    logic [ENERGY_W-1:0] sq;
    logic [NUM_WIN-1:0]  fault;
    logic [127:0]        lhs, rhs;
    logic                grade_b, grade_a;
    out_item_t           res;
    pick = longint'(s.pick_position);
    idx  = longint'(trace_index);
    val  = longint'($signed(s.sample_value));
    sq   = ENERGY_W'(val * val);
    lo[WIN_BEFORE] = pick + longint'($signed(win_cfg.before_start));
    hi[WIN_BEFORE] = pick + longint'($signed(win_cfg.before_end));
    lo[WIN_HIT]    = pick + longint'($signed(win_cfg.hit_start));
    hi[WIN_HIT]    = pick + longint'($signed(win_cfg.hit_end));
    lo[WIN_HALF]   = lo[WIN_HIT];
    hi[WIN_HALF]   = pick + longint'($signed(win_cfg.half_end));
    lo[WIN_AFTER]  = hi[WIN_HALF];
    hi[WIN_AFTER]  = pick + longint'($signed(win_cfg.after_end));
    for (int k = 0; k < NUM_WIN; k++) begin
      if (idx >= lo[k] && idx <= hi[k]) win_energy[k] += sq;
    end
    if (!s.last_sample) begin
      trace_index = trace_index + 1'b1;
      return;
    end

    npts = idx + 1;
    for (int k = 0; k < NUM_WIN; k++) begin
      fault[k] = (lo[k] < 0) || (hi[k] >= npts) || (hi[k] < lo[k]);
      span[k]  = fault[k] ? '0 : ENERGY_W'(hi[k] - lo[k] + 1);
    end
    // a faulted window counts as RMS -1
    if (fault[WIN_BEFORE]) begin
      grade_b = 1'b1;
    end else if (fault[WIN_HIT]) begin
      grade_b = 1'b0;
    end else begin
      lhs = 128'(win_energy[WIN_BEFORE]) * 128'(span[WIN_HIT]) * 128'(RATIO_NUM);
      rhs = 128'(win_energy[WIN_HIT]) * 128'(span[WIN_BEFORE]) * 128'(RATIO_DEN);
      grade_b = lhs < rhs;
    end
    grade_a = 1'b0;
    if (grade_b) begin
      if (fault[WIN_HALF]) begin
        grade_a = 1'b0;
      end else if (fault[WIN_AFTER]) begin
        grade_a = 1'b1;
      end else begin
        lhs = 128'(win_energy[WIN_HALF]) * 128'(span[WIN_AFTER]);
        rhs = 128'(win_energy[WIN_AFTER]) * 128'(span[WIN_HALF]);
        grade_a = rhs < lhs;
      end
    end
    res.quality_grade     = grade_a ? GRADE_A : (grade_b ? GRADE_B : GRADE_C);
    res.window_fault_mask = fault;
    grade_queue.push_back(res);
    clear_sums();
  endtask

  task automatic check_grade(input out_item_t got);
    out_item_t want;
    if (grade_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: grade beat with none due: grade %0d mask %b", $time,
                 got.quality_grade, got.window_fault_mask);
      return;
    end
    want = grade_queue.pop_front();
    if (got.quality_grade !== want.quality_grade ||
        got.window_fault_mask !== want.window_fault_mask) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: grade beat mismatch: expected grade %0d mask %b, got grade %0d mask %b",
                 $time, want.quality_grade, want.window_fault_mask,
                 got.quality_grade, got.window_fault_mask);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg = '{RST_BEFORE_START, RST_BEFORE_END, RST_HIT_START,
                  RST_HIT_END, RST_HALF_END, RST_AFTER_END};
      clear_sums();
      grade_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_offset(paddr, pwdata);
      if (in_valid_i && !in_stall_i) take_sample(in_item_i);
      if (out_valid_i && !out_stall_i) check_grade(out_item_i);
    end
    mismatch_count_o = mismatches;
    pending_count_o  = grade_queue.size();
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives traces of samples and offset register writes into the pick window
// energy classifier under several idle and stall patterns, leaves prediction
// and comparison to the grade checker and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pwrc_pkg::*;

  localparam int ITEM_W = $bits(in_item_t);

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_item_t           in_item_i   = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  out_item_t          out_item_o;
  logic               out_stall_i = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0]  pwdata      = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int   mismatch_count;
  int   pending_count;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  bit   hold_go      = 1'b0;
  int   items_sent   = 0;
  int   traces_sent  = 0;
  cfg_t cur_cfg;

  pick_window_rms_classifier dut (.*);

  pwrc_grade_checker grade_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_item_i        (in_item_i),
    .in_stall_i       (in_stall_o),
    .out_valid_i      (out_valid_o),
    .out_item_i       (out_item_o),
    .out_stall_i      (out_stall_i),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always #5 clk_i = ~clk_i;

  // grade receiver: random stall, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_left = 400;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic set_pace(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
      default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
    endcase
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [OFF_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {16'($urandom()), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_config(input cfg_t c);
    apb_write(REG_BEFORE_START, c.before_start);
    apb_write(REG_BEFORE_END,   c.before_end);
    apb_write(REG_HIT_START,    c.hit_start);
    apb_write(REG_HIT_END,      c.hit_end);
    apb_write(REG_HALF_END,     c.half_end);
    apb_write(REG_AFTER_END,    c.after_end);
    cur_cfg = c;
  endtask

  task automatic send_sample(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      in_item_i  <= ITEM_W'({$urandom(), $urandom()});
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // hold the sender until every grade is back and the back end has settled
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // one trace; amplitude set per region around the pick to spread the grades
  task automatic run_trace(input int len, input int pick, input bit wander);
    in_item_t           it;
    logic signed [23:0] raw;
    int                 sh_pre, sh_hit, sh_post, sh, rel;
    sh_pre  = $urandom_range(23);
    sh_hit  = $urandom_range(23);
    sh_post = $urandom_range(23);
    for (int i = 0; i < len; i++) begin
      rel = (i % 65536) - pick;
      if (rel < int'(cur_cfg.hit_start)) sh = sh_pre;
      else if (rel <= int'(cur_cfg.half_end)) sh = sh_hit;
      else sh = sh_post;
      raw = 24'($urandom());
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(3))
          0: raw = 24'sh800000;
          1: raw = 24'sh7fffff;
          2: raw = '0;
          default: raw = '1;
        endcase
      end else begin
        raw = raw >>> sh;
      end
      it.sample_value  = raw;
      it.pick_position = (wander && $urandom_range(3) == 0) ? INDEX_BITS'($urandom())
                                                            : INDEX_BITS'(pick);
      it.last_sample   = (i == len - 1);
      send_sample(it);
    end
    traces_sent++;
  endtask

  initial begin
    cfg_t c;
    int   bs, be, hs, he, fe, ae, lowest, highest, pick, len, style, round;
    int   item_mark, trace_mark;
    cur_cfg = '{RST_BEFORE_START, RST_BEFORE_END, RST_HIT_START,
                RST_HIT_END, RST_HALF_END, RST_AFTER_END};
    set_pace(0);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes under the reset offsets, pick moving within the trace
    send_sample('{24'sh800000, 16'h0000, 1'b0});
    send_sample('{24'sh7fffff, 16'hffff, 1'b0});
    send_sample('{24'sh000000, 16'h0001, 1'b1});
    // long enough for every default window to fit
    run_trace(5701, 3000, 1'b0);
    wait_idle();

    load_config('{-16'sd6, -16'sd2, -16'sd1, 16'sd4, 16'sd2, 16'sd6});
    run_trace(14, 6, 1'b0);
    run_trace(14, 6, 1'b0);
    run_trace(9, 6, 1'b1);
    wait_idle();
    load_config('{6{16'sh8000}});
    run_trace(4, 0, 1'b0);
    run_trace(4, 65535, 1'b0);
    wait_idle();
    load_config('{6{16'sh7fff}});
    run_trace(4, 0, 1'b0);
    run_trace(4, 65535, 1'b0);
    wait_idle();
    // reversed windows
    load_config('{-16'sd2, -16'sd6, 16'sd4, -16'sd1, 16'sd2, 16'sd1});
    run_trace(12, 6, 1'b0);
    wait_idle();
    // trace past the index range: the sample index wraps
    load_config('{-16'sd2, -16'sd1, 16'sd0, 16'sd2, 16'sd1, 16'sd2});
    run_trace(65541, 2, 1'b0);
    wait_idle();

    item_mark  = items_sent;
    trace_mark = traces_sent;
    round      = 0;
    while (items_sent - item_mark < 1800 || traces_sent - trace_mark < 60) begin
      style = (round % 5 == 3) ? 1 : ((round % 7 == 5) ? 2 : 0);
      if (style == 0) begin
        bs = -int'($urandom_range(4, 16));
        be = bs + int'($urandom_range(6));
        hs = be + int'($urandom_range(6)) - 2;
        fe = hs + int'($urandom_range(6));
        he = fe + int'($urandom_range(6)) - 2;
        ae = fe + int'($urandom_range(8));
      end else if (style == 1) begin
        bs = int'($urandom_range(40)) - 20;
        be = int'($urandom_range(40)) - 20;
        hs = int'($urandom_range(40)) - 20;
        he = int'($urandom_range(40)) - 20;
        fe = int'($urandom_range(40)) - 20;
        ae = int'($urandom_range(40)) - 20;
      end else begin
        bs = ($urandom_range(1)) ? -32768 : int'($urandom_range(40)) - 20;
        be = ($urandom_range(1)) ? 32767 : int'($urandom_range(40)) - 20;
        hs = ($urandom_range(1)) ? -32768 : int'($urandom_range(40)) - 20;
        he = ($urandom_range(1)) ? 32767 : int'($urandom_range(40)) - 20;
        fe = ($urandom_range(1)) ? 32767 : int'($urandom_range(40)) - 20;
        ae = ($urandom_range(1)) ? -32768 : int'($urandom_range(40)) - 20;
      end
      c = '{16'(bs), 16'(be), 16'(hs), 16'(he), 16'(fe), 16'(ae)};
      load_config(c);
      set_pace(round % 4);
      lowest  = (bs < hs) ? bs : hs;
      highest = (he > ae) ? he : ae;
      repeat ($urandom_range(4, 8)) begin
        if (style == 0 && $urandom_range(4) != 0) begin
          pick = -lowest + int'($urandom_range(3));
          len  = pick + highest + 1 + int'($urandom_range(4));
        end else begin
          case ($urandom_range(3))
            0: pick = 0;
            1: pick = 65535;
            default: pick = $urandom_range(40);
          endcase
          len = $urandom_range(1, 40);
        end
        run_trace(len, pick, $urandom_range(7) == 0);
      end
      wait_idle();
      round++;
    end

    // hold the grade side off so the queue fills and samples back up
    load_config('{-16'sd2, -16'sd1, 16'sd0, 16'sd2, 16'sd1, 16'sd3});
    set_pace(0);
    @(posedge clk_i);
    hold_go = 1'b1;
    repeat (30) run_trace($urandom_range(1, 4), 2, 1'b0);
    wait_idle();

    repeat (30) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("pick_window_rms_classifier verification clean");
    end else begin
      $display("pick_window_rms_classifier verification failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("pick_window_rms_classifier verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/pwrc_pkg.sv
rtl/core/pwrc_regs.sv
rtl/core/pwrc_front.sv
rtl/core/pwrc_queue.sv
rtl/core/pwrc_back.sv
rtl/core/pick_window_rms_classifier.sv
rtl/core/pwrc_checker.sv
verif/pwrc_grade_checker.sv
verif/testbench.sv
